FILE: src/lbb_pkg.sv
// Shared types, constants and the sine lookup for the LED blink/breath controller.
package lbb_pkg;

  localparam int unsigned ELAPSED_W  = 32;
  localparam int unsigned ITER_W     = 6;
  localparam int unsigned SINE_BITS  = 8;
  localparam int unsigned CMD_W      = 2;
  localparam int unsigned IN_DATA_W  = 32;
  localparam int unsigned OUT_DATA_W = 32;
  localparam int unsigned EVENTS_W   = 9;
  localparam int unsigned NUMBER_W   = 16;

  localparam logic [7:0] LEVEL_OFF = 8'd0;
  localparam logic [7:0] LEVEL_ON  = 8'd255;
  localparam logic [7:0] LEVEL_MID = 8'd128;

  localparam logic [1:0] STYLE_BREATH = 2'd2;

  typedef enum logic [1:0] {
    CMD_TICK  = 2'd0,
    CMD_START = 2'd1,
    CMD_SET   = 2'd2,
    CMD_NONE  = 2'd3
  } lbb_cmd_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DIV_N,
    ST_DIV_P,
    ST_DIV_S,
    ST_FINISH
  } lbb_state_e;

  typedef enum logic [1:0] {
    DIV_PERIOD,
    DIV_HALF,
    DIV_SINE
  } lbb_div_op_e;

  typedef struct packed {
    logic        load;
    logic        div_start;
    lbb_div_op_e div_op;
    logic        save_n;
    logic        commit;
  } lbb_ctrl_t;

  typedef struct packed {
    logic in_tick;
    logic div_busy;
    logic need_sine;
    logic need_par;
    logic out_free;
  } lbb_stat_t;

  // round(128 * sin(pi/2 * j / 64)) for j = 0..64
  localparam logic [7:0] QUARTER_SINE [65] = '{
    8'd0,   8'd3,   8'd6,   8'd9,   8'd13,  8'd16,  8'd19,  8'd22,
    8'd25,  8'd28,  8'd31,  8'd34,  8'd37,  8'd40,  8'd43,  8'd46,
    8'd49,  8'd52,  8'd55,  8'd58,  8'd60,  8'd63,  8'd66,  8'd68,
    8'd71,  8'd74,  8'd76,  8'd79,  8'd81,  8'd84,  8'd86,  8'd88,
    8'd91,  8'd93,  8'd95,  8'd97,  8'd99,  8'd101, 8'd103, 8'd105,
    8'd106, 8'd108, 8'd110, 8'd111, 8'd113, 8'd114, 8'd116, 8'd117,
    8'd118, 8'd119, 8'd121, 8'd122, 8'd122, 8'd123, 8'd124, 8'd125,
    8'd126, 8'd126, 8'd127, 8'd127, 8'd127, 8'd128, 8'd128, 8'd128,
    8'd128
  };

  // Full-wave level clamp(128 + round(128*sin(2*pi*idx/256)), 0, 255) folded from a quarter wave.
  function automatic logic [7:0] sine_level(input logic [SINE_BITS-1:0] idx);
    logic [6:0] j;
    logic [7:0] mag;
    logic [8:0] sum;
    begin
      if (idx[6]) begin
        j = 7'd64 - {1'b0, idx[5:0]};
      end else begin
        j = {1'b0, idx[5:0]};
      end
      mag = QUARTER_SINE[j];
      sum = {1'b0, LEVEL_MID} + {1'b0, mag};
      if (idx[7]) begin
        sine_level = LEVEL_MID - mag;
      end else if (sum[8]) begin
        sine_level = LEVEL_ON;
      end else begin
        sine_level = sum[7:0];
      end
    end
  endfunction

endpackage

FILE: src/lbb_div.sv
// Bit-serial restoring divider, one quotient bit per cycle.
module lbb_div #(
  parameter int unsigned DIVIDEND_W = 32,
  parameter int unsigned DIVISOR_W  = 16,
  parameter int unsigned CNT_W      = 6
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  start_i,
  input  logic [DIVIDEND_W-1:0] dividend_i,
  input  logic [DIVISOR_W-1:0]  init_rem_i,   // must be below divisor_i
  input  logic [DIVISOR_W-1:0]  divisor_i,
  input  logic [CNT_W-1:0]      iters_i,
  output logic                  busy_o,
  output logic [DIVIDEND_W-1:0] quo_o,
  output logic [DIVISOR_W-1:0]  rem_o
);

  logic                  busy_q, busy_d;
  logic [CNT_W-1:0]      cnt_q, cnt_d;
  logic [DIVIDEND_W-1:0] quo_q, quo_d;
  logic [DIVISOR_W-1:0]  rem_q, rem_d;
  logic [DIVISOR_W-1:0]  dvs_q, dvs_d;
  logic [DIVISOR_W:0]    shifted;
  logic [DIVISOR_W:0]    diff;
  logic                  fits;

  always_comb begin
    shifted = {rem_q, quo_q[DIVIDEND_W-1]};
    diff    = shifted - {1'b0, dvs_q};
    fits    = shifted >= {1'b0, dvs_q};

    busy_d = busy_q;
    cnt_d  = cnt_q;
    quo_d  = quo_q;
    rem_d  = rem_q;
    dvs_d  = dvs_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = iters_i;
      quo_d  = dividend_i;
      rem_d  = init_rem_i;
      dvs_d  = divisor_i;
    end else if (busy_q) begin
      quo_d = {quo_q[DIVIDEND_W-2:0], fits};
      rem_d = fits ? diff[DIVISOR_W-1:0] : shifted[DIVISOR_W-1:0];
      cnt_d = cnt_q - CNT_W'(1);
      if (cnt_q == CNT_W'(1)) begin
        busy_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quo_q <= quo_d;
    rem_q <= rem_d;
    dvs_q <= dvs_d;
  end

  assign busy_o = busy_q;
  assign quo_o  = quo_q;
  assign rem_o  = rem_q;

endmodule

FILE: src/lbb_datapath.sv
// Datapath: item latch, blink state, divider operand selection and result register.
module lbb_datapath #(
  parameter int unsigned PERIOD_BITS = 16
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  lbb_pkg::lbb_ctrl_t                   ctrl_i,
  output lbb_pkg::lbb_stat_t                   stat_o,
  input  logic [lbb_pkg::CMD_W-1:0]            s_tuser_i,
  input  logic [lbb_pkg::IN_DATA_W-1:0]        s_tdata_i,
  input  logic                                 m_tready_i,
  output logic                                 m_tvalid_o,
  output logic [lbb_pkg::OUT_DATA_W-1:0]       m_tdata_o
);

  localparam int unsigned EW = lbb_pkg::ELAPSED_W;

  // latched item
  lbb_pkg::lbb_cmd_e      cmd_q;
  logic                   on_in_q;
  logic [7:0]             cnt_in_q;
  logic [PERIOD_BITS-1:0] per_in_q;
  logic [1:0]             style_in_q;

  // blink state
  logic [EW-1:0]                  elapsed_q, elapsed_d;
  logic [7:0]                     total_q, total_d;
  logic [PERIOD_BITS-1:0]         period_q, period_d;
  logic [1:0]                     style_q, style_d;
  logic [lbb_pkg::EVENTS_W-1:0]   events_q, events_d;
  logic                           started_q, started_d;
  logic                           steady_q, steady_d;
  logic                           pwm_q, pwm_d;
  logic [7:0]                     drive_q, drive_d;
  logic                           event_q, event_d;
  logic [lbb_pkg::NUMBER_W-1:0]   num_q, num_d;
  logic                           m_valid_q, m_valid_d;

  // period quotient and remainder of the current tick
  logic [EW-1:0]          n_q;
  logic [PERIOD_BITS-1:0] r_q;

  // divider
  logic [EW-1:0]                 div_dividend;
  logic [PERIOD_BITS-1:0]        div_init_rem;
  logic [PERIOD_BITS-1:0]        div_divisor;
  logic [lbb_pkg::ITER_W-1:0]    div_iters;
  logic                          div_busy;
  logic [EW-1:0]                 div_quo;
  logic [PERIOD_BITS-1:0]        div_rem;

  logic [PERIOD_BITS-1:0] half;
  logic                   run_on;
  logic                   parity;
  logic [7:0]             square_level;
  logic [7:0]             steady_level;
  logic                   carry;
  logic [EW:0]            next_n;
  logic [EW+1:0]          num_full;
  logic [lbb_pkg::NUMBER_W-1:0] num_tick;
  logic                   cancel;

  assign half = (period_q[PERIOD_BITS-1:1] == '0) ? PERIOD_BITS'(1)
                                                  : {1'b0, period_q[PERIOD_BITS-1:1]};

  always_comb begin
    div_dividend = elapsed_q;
    div_init_rem = '0;
    div_divisor  = period_q;
    div_iters    = lbb_pkg::ITER_W'(EW);
    case (ctrl_i.div_op)
      lbb_pkg::DIV_PERIOD: begin
        div_divisor = period_q;
      end
      lbb_pkg::DIV_HALF: begin
        div_divisor = half;
      end
      lbb_pkg::DIV_SINE: begin
        // scale the phase by the table size: long division of rem << SINE_BITS
        div_dividend = '0;
        div_init_rem = div_rem;
        div_iters    = lbb_pkg::ITER_W'(lbb_pkg::SINE_BITS);
      end
      default: begin
        div_divisor = period_q;
      end
    endcase
  end

  lbb_div #(
    .DIVIDEND_W (EW),
    .DIVISOR_W  (PERIOD_BITS),
    .CNT_W      (lbb_pkg::ITER_W)
  ) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (ctrl_i.div_start),
    .dividend_i (div_dividend),
    .init_rem_i (div_init_rem),
    .divisor_i  (div_divisor),
    .iters_i    (div_iters),
    .busy_o     (div_busy),
    .quo_o      (div_quo),
    .rem_o      (div_rem)
  );

  // status is read by the controller right after the period quotient settles
  assign run_on = (total_q != '0) && (div_quo < EW'(total_q));

  always_comb begin
    stat_o           = '0;
    stat_o.in_tick   = (lbb_pkg::lbb_cmd_e'(s_tuser_i) == lbb_pkg::CMD_TICK);
    stat_o.div_busy  = div_busy;
    stat_o.need_sine = run_on && (style_q == lbb_pkg::STYLE_BREATH);
    stat_o.need_par  = run_on && (style_q != lbb_pkg::STYLE_BREATH) && period_q[0]
                       && (period_q != PERIOD_BITS'(1));
    stat_o.out_free  = !m_valid_q || m_tready_i;
  end

  always_comb begin
    // parity of elapsed / half: even periods follow from the remainder directly
    if (!period_q[0]) begin
      parity = (r_q >= half);
    end else if (period_q == PERIOD_BITS'(1)) begin
      parity = elapsed_q[0];
    end else begin
      parity = div_quo[0];
    end
    square_level = ({1'b0, parity} == style_q) ? lbb_pkg::LEVEL_OFF : lbb_pkg::LEVEL_ON;
    steady_level = steady_q ? lbb_pkg::LEVEL_ON : lbb_pkg::LEVEL_OFF;

    // quotient of elapsed + 1 without another division
    carry = ({1'b0, r_q} + (PERIOD_BITS + 1)'(1)) == {1'b0, period_q};
    if (&elapsed_q) begin
      next_n = '0;
    end else begin
      next_n = {1'b0, n_q} + (EW + 1)'(carry);
    end
    num_full = {1'b0, next_n} + (EW + 2)'(1);
    if (num_full > (EW + 2)'({lbb_pkg::NUMBER_W{1'b1}})) begin
      num_tick = '1;
    end else begin
      num_tick = num_full[lbb_pkg::NUMBER_W-1:0];
    end
    cancel = (cnt_in_q == '0) || (per_in_q == '0);
  end

  always_comb begin
    elapsed_d = elapsed_q;
    total_d   = total_q;
    period_d  = period_q;
    style_d   = style_q;
    events_d  = events_q;
    started_d = started_q;
    steady_d  = steady_q;
    pwm_d     = pwm_q;
    drive_d   = drive_q;
    event_d   = event_q;
    num_d     = num_q;
    m_valid_d = m_valid_q && !m_tready_i;

    if (ctrl_i.commit) begin
      m_valid_d = 1'b1;
      event_d   = 1'b0;
      case (cmd_q)
        lbb_pkg::CMD_SET: begin
          steady_d = on_in_q;
          drive_d  = on_in_q ? lbb_pkg::LEVEL_ON : lbb_pkg::LEVEL_OFF;
          total_d  = '0;
        end
        lbb_pkg::CMD_START: begin
          events_d = '0;
          style_d  = style_in_q;
          if (cancel) begin
            total_d   = '0;
            period_d  = PERIOD_BITS'(1);
            started_d = 1'b0;
            drive_d   = steady_level;
            num_d     = '0;
          end else begin
            total_d   = cnt_in_q;
            period_d  = per_in_q;
            started_d = 1'b1;
            elapsed_d = '0;
            num_d     = lbb_pkg::NUMBER_W'(1);
          end
        end
        lbb_pkg::CMD_TICK: begin
          if (total_q != '0) begin
            if (n_q >= EW'(total_q)) begin
              total_d = '0;
              drive_d = steady_level;
            end else begin
              if (style_q == lbb_pkg::STYLE_BREATH) begin
                drive_d = lbb_pkg::sine_level(div_quo[lbb_pkg::SINE_BITS-1:0]);
                pwm_d   = 1'b1;
              end else begin
                drive_d = square_level;
              end
              if (n_q >= EW'(events_q)) begin
                event_d  = 1'b1;
                events_d = n_q[lbb_pkg::EVENTS_W-1:0] + lbb_pkg::EVENTS_W'(1);
              end
            end
          end
          elapsed_d = elapsed_q + EW'(1);
          num_d     = started_q ? num_tick : '0;
        end
        default: begin
          // unused command: report the held state
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      elapsed_q <= '0;
      total_q   <= '0;
      period_q  <= PERIOD_BITS'(1);
      style_q   <= '0;
      events_q  <= '0;
      started_q <= 1'b0;
      steady_q  <= 1'b0;
      pwm_q     <= 1'b0;
      drive_q   <= '0;
      event_q   <= 1'b0;
      num_q     <= '0;
      m_valid_q <= 1'b0;
    end else begin
      elapsed_q <= elapsed_d;
      total_q   <= total_d;
      period_q  <= period_d;
      style_q   <= style_d;
      events_q  <= events_d;
      started_q <= started_d;
      steady_q  <= steady_d;
      pwm_q     <= pwm_d;
      drive_q   <= drive_d;
      event_q   <= event_d;
      num_q     <= num_d;
      m_valid_q <= m_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.load) begin
      cmd_q      <= lbb_pkg::lbb_cmd_e'(s_tuser_i);
      on_in_q    <= s_tdata_i[0];
      cnt_in_q   <= s_tdata_i[8:1];
      per_in_q   <= PERIOD_BITS'(s_tdata_i[24:9]);
      style_in_q <= s_tdata_i[26:25];
    end
    if (ctrl_i.save_n) begin
      n_q <= div_quo;
      r_q <= div_rem;
    end
  end

  assign m_tvalid_o = m_valid_q;
  assign m_tdata_o  = {5'b0, num_q, (total_q != '0), event_q, pwm_q, drive_q};

endmodule

FILE: src/lbb_ctrl.sv
// Controller FSM: sequences item capture, divider passes and result commit.
module lbb_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               s_tvalid_i,
  output logic               s_tready_o,
  input  lbb_pkg::lbb_stat_t stat_i,
  output lbb_pkg::lbb_ctrl_t ctrl_o
);

  lbb_pkg::lbb_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= lbb_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d       = state_q;
    ctrl_o        = '0;
    ctrl_o.div_op = lbb_pkg::DIV_PERIOD;
    s_tready_o    = 1'b0;
    case (state_q)
      lbb_pkg::ST_IDLE: begin
        s_tready_o = 1'b1;
        if (s_tvalid_i) begin
          ctrl_o.load = 1'b1;
          if (stat_i.in_tick) begin
            ctrl_o.div_start = 1'b1;
            ctrl_o.div_op    = lbb_pkg::DIV_PERIOD;
            state_d          = lbb_pkg::ST_DIV_N;
          end else begin
            state_d = lbb_pkg::ST_FINISH;
          end
        end
      end
      lbb_pkg::ST_DIV_N: begin
        if (!stat_i.div_busy) begin
          ctrl_o.save_n = 1'b1;
          if (stat_i.need_sine) begin
            ctrl_o.div_start = 1'b1;
            ctrl_o.div_op    = lbb_pkg::DIV_SINE;
            state_d          = lbb_pkg::ST_DIV_S;
          end else if (stat_i.need_par) begin
            ctrl_o.div_start = 1'b1;
            ctrl_o.div_op    = lbb_pkg::DIV_HALF;
            state_d          = lbb_pkg::ST_DIV_P;
          end else begin
            state_d = lbb_pkg::ST_FINISH;
          end
        end
      end
      lbb_pkg::ST_DIV_P, lbb_pkg::ST_DIV_S: begin
        if (!stat_i.div_busy) begin
          state_d = lbb_pkg::ST_FINISH;
        end
      end
      lbb_pkg::ST_FINISH: begin
        // hold until the previous result has been taken
        if (stat_i.out_free) begin
          ctrl_o.commit = 1'b1;
          state_d       = lbb_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = lbb_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

FILE: src/led_blink_breath_controller_core.sv
// LED blink/breath controller: top level joining controller and datapath.
//
// Slave stream carries one command per transfer: tuser selects tick, start or
// set; tdata carries the steady level, blink count, period and style. Every
// accepted command produces exactly one result transfer on the master stream
// with the drive level, PWM mode flag, period-start event, run-active flag
// and the current blink number.
// Set, start and the unused command go from capture straight to the result
// commit. A tick first runs the shared bit-serial divider to form
// elapsed / period (one quotient bit per cycle over 32 bits); in an active run,
// breathing adds a divider pass for the sine index and square blinking with
// an odd period above one adds a pass over elapsed / half for the parity.
// One command is in work at a time; tready is high while the controller waits
// for a command, also while an earlier result is still pending.
// If the receiver stalls, the finished command waits until the pending result
// has been transferred; the pending result holds steady meanwhile.
// Reset clears the run, the steady level, the PWM flag and the time base, and
// sets the period to one; no result is pending after reset.
module led_blink_breath_controller_core #(
  parameter int unsigned PERIOD_BITS = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [31:0] s_axis_tdata,   // on_level, blink_count[8], period_ms[16], blink_style[2]
  input  logic [1:0]  s_axis_tuser,   // command
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [31:0] m_axis_tdata    // pin_level[8], analog_mode, cycle_event, blink_active,
                                      // blink_number[16]
);

  lbb_pkg::lbb_ctrl_t ctrl;
  lbb_pkg::lbb_stat_t stat;

  lbb_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .s_tvalid_i (s_axis_tvalid),
    .s_tready_o (s_axis_tready),
    .stat_i     (stat),
    .ctrl_o     (ctrl)
  );

  lbb_datapath #(
    .PERIOD_BITS (PERIOD_BITS)
  ) u_datapath (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .ctrl_i     (ctrl),
    .stat_o     (stat),
    .s_tuser_i  (s_axis_tuser),
    .s_tdata_i  (s_axis_tdata),
    .m_tready_i (m_axis_tready),
    .m_tvalid_o (m_axis_tvalid),
    .m_tdata_o  (m_axis_tdata)
  );

endmodule

FILE: src/lbb_checker.sv
// Port-level checker for the LED blink/breath controller, bound to the top level.
module lbb_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tvalid,
  input logic        s_axis_tready,
  input logic [31:0] s_axis_tdata,
  input logic [1:0]  s_axis_tuser,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [31:0] m_axis_tdata
);

  // stalled result holds
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result changed while stalled");

  // a period-start event only occurs inside a live run
  a_event_active: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tdata[9] |-> m_axis_tdata[10])
    else $error("cycle event without an active run");

  a_event_number: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tdata[9] |-> m_axis_tdata[26:11] != 16'd0)
    else $error("cycle event with zero blink number");

  // PWM mode is sticky once reported
  a_pwm_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $past(m_axis_tvalid && m_axis_tready && m_axis_tdata[8]) && m_axis_tvalid
      |-> m_axis_tdata[8])
    else $error("analog mode cleared");

endmodule

bind led_blink_breath_controller_core lbb_checker u_lbb_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .s_axis_tdata  (s_axis_tdata),
  .s_axis_tuser  (s_axis_tuser),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);
